### rtl/cfh_pkg.sv
package cfh_pkg;

    // Axis readings and result widths.
    localparam int AXIS_W    = 16;
    localparam int HEADING_W = 15;
    localparam int IN_W      = 3 * AXIS_W;
    localparam int OUT_W     = ((3 * AXIS_W + HEADING_W + 7) / 8) * 8;

    // CORDIC set-up: the readings are scaled by 2^PRESCALE_SHIFT before the
    // iterations, and the vector carries enough headroom for the gain.
    localparam int ANGLE_STEPS    = 16;
    localparam int TABLE_LEN      = 24;
    localparam int CORDIC_STEPS   = (ANGLE_STEPS < TABLE_LEN) ? ANGLE_STEPS : TABLE_LEN;
    localparam int PRESCALE_SHIFT = 8;
    localparam int CORDIC_W       = AXIS_W + PRESCALE_SHIFT + 3;
    localparam int ANGLE_W        = 32;
    localparam int STEP_IDX_W     = 5;
    localparam int PROD_W         = ANGLE_W + HEADING_W;

    localparam logic [ANGLE_W-1:0]   HALF_TURN_ANGLE = 32'h8000_0000;
    localparam logic [HEADING_W-1:0] FULL_TURN_UNITS = 15'd23040;
    localparam logic [HEADING_W-1:0] HALF_TURN_UNITS = 15'd11520;

    typedef struct packed {
        logic signed [AXIS_W-1:0]   x;
        logic signed [AXIS_W-1:0]   y;
        logic signed [AXIS_W-1:0]   z;
        logic                       yzero;
        logic                       xneg;
        logic signed [CORDIC_W-1:0] cx;
        logic signed [CORDIC_W-1:0] cy;
        logic [ANGLE_W-1:0]         ang;
    } cord_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
        logic                     yzero;
        logic                     xneg;
        logic [PROD_W-1:0]        prod;
    } prod_t;

    // atan(2^-i) as a binary angle, 2^32 being one full turn.
    function automatic logic [ANGLE_W-1:0] arc_atan(input logic [STEP_IDX_W-1:0] idx);
        logic [ANGLE_W-1:0] a;
        begin
            case (idx)
                5'd0:    a = 32'h2000_0000;
                5'd1:    a = 32'h12E4_051E;
                5'd2:    a = 32'h09FB_385B;
                5'd3:    a = 32'h0511_11D4;
                5'd4:    a = 32'h028B_0D43;
                5'd5:    a = 32'h0145_D7E1;
                5'd6:    a = 32'h00A2_F61E;
                5'd7:    a = 32'h0051_7C55;
                5'd8:    a = 32'h0028_BE53;
                5'd9:    a = 32'h0014_5F2F;
                5'd10:   a = 32'h000A_2F98;
                5'd11:   a = 32'h0005_17CC;
                5'd12:   a = 32'h0002_8BE6;
                5'd13:   a = 32'h0001_45F3;
                5'd14:   a = 32'h0000_A2FA;
                5'd15:   a = 32'h0000_517D;
                5'd16:   a = 32'h0000_28BE;
                5'd17:   a = 32'h0000_145F;
                5'd18:   a = 32'h0000_0A30;
                5'd19:   a = 32'h0000_0518;
                5'd20:   a = 32'h0000_028C;
                5'd21:   a = 32'h0000_0146;
                5'd22:   a = 32'h0000_00A3;
                5'd23:   a = 32'h0000_0051;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

    // One vectoring iteration; both updates use the vector from before it.
    function automatic cord_t cord_step(input cord_t s, input logic [STEP_IDX_W-1:0] idx);
        cord_t                      r;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        begin
            r  = s;
            dx = s.cx >>> idx;
            dy = s.cy >>> idx;
            if (!s.cy[CORDIC_W-1])
            begin
                r.cx  = s.cx + dy;
                r.cy  = s.cy - dx;
                r.ang = s.ang + arc_atan(idx);
            end
            else
            begin
                r.cx  = s.cx - dy;
                r.cy  = s.cy + dx;
                r.ang = s.ang - arc_atan(idx);
            end
            return r;
        end
    endfunction

endpackage

### rtl/compass_heading_from_axes.sv
// Channel   Direction  tdata fields (low bit up)                 Handshake
// s_axis    in         axis_x[15:0] axis_y[31:16] axis_z[47:32]  tvalid/tready
// m_axis    out        out_x[15:0] out_y[31:16] out_z[47:32]     tvalid/tready
//                      heading[62:48], bit 63 zero
//
// One word is accepted per cycle unless the output stalls; a result passes
// through one register per CORDIC iteration plus the pre-rotation, multiply and
// output stages.
// Reset clears only the valid bits; the data registers are left as they are.
// A stall at the output holds the output word; empty stages behind it still
// fill, so input is refused only when every stage holds a word.
module compass_heading_from_axes (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // axis_x, axis_y, axis_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // out_x, out_y, out_z, heading, pad
);

    localparam int NS = cfh_pkg::CORDIC_STEPS;

    cfh_pkg::cord_t st_reg  [NS+1];
    cfh_pkg::cord_t st_next [NS+1];
    logic [NS:0]    cv_reg;
    logic [NS+2:0]  rdy;

    cfh_pkg::prod_t prod_reg;
    cfh_pkg::prod_t prod_next;
    logic           prod_valid_reg;

    logic [cfh_pkg::OUT_W-1:0] out_reg;
    logic [cfh_pkg::OUT_W-1:0] out_next;
    logic                      out_valid_reg;

    logic signed [cfh_pkg::AXIS_W-1:0]   in_x;
    logic signed [cfh_pkg::AXIS_W-1:0]   in_y;
    logic signed [cfh_pkg::AXIS_W-1:0]   in_z;
    logic signed [cfh_pkg::CORDIC_W-1:0] px;
    logic signed [cfh_pkg::CORDIC_W-1:0] py;
    logic [cfh_pkg::PROD_W:0]            rounded;
    logic [cfh_pkg::HEADING_W:0]         hsum;
    logic [cfh_pkg::HEADING_W-1:0]       heading;

    assign in_x = s_axis_tdata[cfh_pkg::AXIS_W-1:0];
    assign in_y = s_axis_tdata[2*cfh_pkg::AXIS_W-1:cfh_pkg::AXIS_W];
    assign in_z = s_axis_tdata[3*cfh_pkg::AXIS_W-1:2*cfh_pkg::AXIS_W];

    // Ready ripples back from the output: a stage may load when it is empty
    // or its word moves on in the same cycle.
    always_comb
    begin
        rdy[NS+2] = !out_valid_reg || m_axis_tready;
        rdy[NS+1] = !prod_valid_reg || rdy[NS+2];
        for (int k = NS; k >= 0; k--)
        begin
            rdy[k] = !cv_reg[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[0];

    // Pre-rotation: scale the readings and fold the left half-plane over.
    always_comb
    begin
        px = {{(cfh_pkg::CORDIC_W-cfh_pkg::AXIS_W-cfh_pkg::PRESCALE_SHIFT){in_x[15]}},
              in_x, {cfh_pkg::PRESCALE_SHIFT{1'b0}}};
        py = {{(cfh_pkg::CORDIC_W-cfh_pkg::AXIS_W-cfh_pkg::PRESCALE_SHIFT){in_y[15]}},
              in_y, {cfh_pkg::PRESCALE_SHIFT{1'b0}}};
        st_next[0].x     = in_x;
        st_next[0].y     = in_y;
        st_next[0].z     = in_z;
        st_next[0].yzero = (in_y == '0);
        st_next[0].xneg  = in_x[cfh_pkg::AXIS_W-1];
        if (in_x[cfh_pkg::AXIS_W-1])
        begin
            st_next[0].cx  = -px;
            st_next[0].cy  = -py;
            st_next[0].ang = cfh_pkg::HALF_TURN_ANGLE;
        end
        else
        begin
            st_next[0].cx  = px;
            st_next[0].cy  = py;
            st_next[0].ang = '0;
        end
        for (int k = 1; k <= NS; k++)
        begin
            st_next[k] = cfh_pkg::cord_step(st_reg[k-1],
                                            cfh_pkg::STEP_IDX_W'(k - 1));
        end
    end

    always_comb
    begin
        prod_next.x     = st_reg[NS].x;
        prod_next.y     = st_reg[NS].y;
        prod_next.z     = st_reg[NS].z;
        prod_next.yzero = st_reg[NS].yzero;
        prod_next.xneg  = st_reg[NS].xneg;
        prod_next.prod  = cfh_pkg::PROD_W'(st_reg[NS].ang)
                        * cfh_pkg::PROD_W'(cfh_pkg::FULL_TURN_UNITS);
    end

    // Round half up to 1/64 degree; a rounded full turn wraps to zero; zero y gives 0 or half a turn.
    always_comb
    begin
        rounded = {1'b0, prod_reg.prod}
                + (cfh_pkg::PROD_W+1)'(cfh_pkg::HALF_TURN_ANGLE);
        hsum    = rounded[cfh_pkg::PROD_W:cfh_pkg::ANGLE_W];
        if (prod_reg.yzero)
        begin
            heading = prod_reg.xneg ? cfh_pkg::HALF_TURN_UNITS : '0;
        end
        else if (hsum >= {1'b0, cfh_pkg::FULL_TURN_UNITS})
        begin
            heading = '0;
        end
        else
        begin
            heading = hsum[cfh_pkg::HEADING_W-1:0];
        end
        out_next = {{(cfh_pkg::OUT_W-cfh_pkg::IN_W-cfh_pkg::HEADING_W){1'b0}},
                    heading, prod_reg.z, prod_reg.y, prod_reg.x};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg         <= '0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rdy[0])
            begin
                cv_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k <= NS; k++)
            begin
                if (rdy[k])
                begin
                    cv_reg[k] <= cv_reg[k-1];
                end
            end
            if (rdy[NS+1])
            begin
                prod_valid_reg <= cv_reg[NS];
            end
            if (rdy[NS+2])
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && s_axis_tvalid)
        begin
            st_reg[0] <= st_next[0];
        end
        for (int k = 1; k <= NS; k++)
        begin
            if (rdy[k] && cv_reg[k-1])
            begin
                st_reg[k] <= st_next[k];
            end
        end
        if (rdy[NS+1] && cv_reg[NS])
        begin
            prod_reg <= prod_next;
        end
        if (rdy[NS+2] && prod_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

`ifndef NO_ASSERTIONS
    // With the output stage empty, every stage behind it can take a word.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused while output stage is empty");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[62:48] < 15'd23040))
        else $error("heading beyond a full turn");

    a_yzero_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid_reg && rdy[NS+2] && prod_reg.yzero && !prod_reg.xneg)
        |=> (m_axis_tdata[62:48] == '0))
        else $error("zero y with non-negative x must give heading zero");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_WORDS = 1200;
    localparam int CALM_TAIL    = 150;
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_AT     = 800;
    localparam int SETTLE_WAIT  = 40;
    localparam int STALL_LIMIT  = 1000;
    localparam int REPORT_MAX   = 10;
    localparam int ARC_ENTRIES  = 24;

    // atan(2^-k) as a binary angle, one full turn being 2^32.
    localparam logic [31:0] ARC_TURN [ARC_ENTRIES] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    typedef struct {
        logic signed [cfh_pkg::AXIS_W-1:0] x;
        logic signed [cfh_pkg::AXIS_W-1:0] y;
        logic signed [cfh_pkg::AXIS_W-1:0] z;
        bit                                settle;
    } sample_t;

    typedef struct {
        logic signed [cfh_pkg::AXIS_W-1:0] x;
        logic signed [cfh_pkg::AXIS_W-1:0] y;
        logic signed [cfh_pkg::AXIS_W-1:0] z;
        logic [cfh_pkg::HEADING_W-1:0]     heading;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // axis_x, axis_y, axis_z
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // out_x, out_y, out_z, heading, pad

    sample_t  samples_waiting[$];
    reading_t headings_due[$];
    sample_t  in_flight;

    int  words_total = 0;
    int  words_in = 0;
    int  results_out = 0;
    int  faults = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    bit  rx_hold = 1'b0;

    compass_heading_from_axes DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Vectoring CORDIC on 64-bit integers, the angle wrapping modulo one turn.
    function automatic logic [cfh_pkg::HEADING_W-1:0] predict_heading(
        input logic signed [cfh_pkg::AXIS_W-1:0] ax,
        input logic signed [cfh_pkg::AXIS_W-1:0] ay);
        longint      vx;
        longint      vy;
        longint      sx;
        longint      sy;
        logic [31:0] turn;
        logic [63:0] scaled;
        logic [63:0] units;
        begin
            if (ay == 0)
                return (ax < 0) ? cfh_pkg::HALF_TURN_UNITS : '0;
            vx = longint'(ax) * 256;
            vy = longint'(ay) * 256;
            turn = '0;
            if (vx < 0)
            begin
                vx = -vx;
                vy = -vy;
                turn = 32'h8000_0000;
            end
            for (int k = 0; k < cfh_pkg::ANGLE_STEPS && k < ARC_ENTRIES; k++)
            begin
                sx = vx >>> k;
                sy = vy >>> k;
                if (vy >= 0)
                begin
                    vx = vx + sy;
                    vy = vy - sx;
                    turn = turn + ARC_TURN[k];
                end
                else
                begin
                    vx = vx - sy;
                    vy = vy + sx;
                    turn = turn - ARC_TURN[k];
                end
            end
            scaled = {32'd0, turn} * 64'd23040 + 64'h8000_0000;
            units = scaled >> 32;
            if (units >= 64'd23040)
                units = '0;
            return units[cfh_pkg::HEADING_W-1:0];
        end
    endfunction

    function automatic void fault(input string msg);
        begin
            faults++;
            if (faults <= REPORT_MAX)
                $display("%0t: %s", $realtime, msg);
        end
    endfunction

    task automatic queue_sample(input logic signed [cfh_pkg::AXIS_W-1:0] x,
                                input logic signed [cfh_pkg::AXIS_W-1:0] y,
                                input logic signed [cfh_pkg::AXIS_W-1:0] z,
                                input bit settle);
        sample_t s;
        begin
            s.x = x;
            s.y = y;
            s.z = z;
            s.settle = settle;
            samples_waiting.push_back(s);
            words_total++;
        end
    endtask

    // Mostly full-range values, with the extremes and values near zero kept common.
    function automatic logic signed [cfh_pkg::AXIS_W-1:0] pick_axis();
        begin
            case ($urandom_range(0, 9))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2, 3:    return 16'($urandom_range(0, 32) - 16);
                default: return 16'($urandom());
            endcase
        end
    endfunction

    // Driver: presents queued words and records what each accepted word must produce.
    always @(posedge clk)
    begin
        reading_t r;
        bit       taken;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            taken = s_axis_tvalid && s_axis_tready;
            if (taken)
            begin
                r.x = in_flight.x;
                r.y = in_flight.y;
                r.z = in_flight.z;
                r.heading = predict_heading(in_flight.x, in_flight.y);
                headings_due.push_back(r);
                words_in <= words_in + 1;
                if (!quiet && ((samples_waiting.size() / 128) % 3 != 0)
                    && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 7);
            end
            if (!s_axis_tvalid || taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (samples_waiting.size() != 0 && samples_waiting[0].settle
                         && results_out != words_in + int'(taken))
                    s_axis_tvalid <= 1'b0;
                else if (samples_waiting.size() != 0)
                begin
                    in_flight = samples_waiting.pop_front();
                    s_axis_tdata <= {in_flight.z, in_flight.y, in_flight.x};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            quiet <= (samples_waiting.size() < CALM_TAIL);
        end
    end

    // Monitor: compares each accepted result word with the oldest one due.
    always @(posedge clk)
    begin
        reading_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_out <= results_out + 1;
                if (headings_due.size() == 0)
                    fault($sformatf("result word %h arrived with none due", m_axis_tdata));
                else
                begin
                    want = headings_due.pop_front();
                    if (m_axis_tdata[15:0] !== want.x)
                        fault($sformatf("out_x: expected %0d, got %0d",
                                        want.x, $signed(m_axis_tdata[15:0])));
                    if (m_axis_tdata[31:16] !== want.y)
                        fault($sformatf("out_y: expected %0d, got %0d",
                                        want.y, $signed(m_axis_tdata[31:16])));
                    if (m_axis_tdata[47:32] !== want.z)
                        fault($sformatf("out_z: expected %0d, got %0d",
                                        want.z, $signed(m_axis_tdata[47:32])));
                    if (m_axis_tdata[62:48] !== want.heading)
                        fault($sformatf("heading for x=%0d y=%0d: expected %0d, got %0d",
                                        want.x, want.y, want.heading,
                                        m_axis_tdata[62:48]));
                    if (m_axis_tdata[63] !== 1'b0)
                        fault($sformatf("pad bit: expected 0, got %b", m_axis_tdata[63]));
                end
            end
            if (rx_hold)
                m_axis_tready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && ((results_out / 100) % 3 != 1) && $urandom_range(0, 4) == 0)
            begin
                recv_gap = $urandom_range(1, 7) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // A long output stall while input keeps coming, so the pipeline backs up.
    initial
    begin
        wait (words_in >= HOLD_AFTER);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic signed [cfh_pkg::AXIS_W-1:0] rx;
        logic signed [cfh_pkg::AXIS_W-1:0] ry;

        // Zero y bypasses the rotation: 180 degrees for negative x, else 0.
        queue_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
        queue_sample(16'sh7FFF, 16'sd0, 16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, 16'sd0, 16'sh8000, 1'b0);
        queue_sample(16'sd1, 16'sd0, -16'sd1, 1'b0);
        queue_sample(-16'sd1, 16'sd0, 16'sd1, 1'b0);
        // Zero x: straight up and straight down.
        queue_sample(16'sd0, 16'sh7FFF, 16'sd0, 1'b0);
        queue_sample(16'sd0, 16'sh8000, 16'sh7FFF, 1'b0);
        // The four corners of the input range.
        queue_sample(16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0);
        queue_sample(16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0);
        queue_sample(16'sh7FFF, 16'sh8000, 16'sd0, 1'b0);
        queue_sample(16'sh8000, 16'sh7FFF, -16'sd1, 1'b0);
        // Just either side of zero heading; below a full turn the rounded heading wraps to zero.
        queue_sample(16'sh7FFF, -16'sd1, 16'sd1, 1'b0);
        queue_sample(16'sh7FFF, 16'sd1, 16'sh8000, 1'b0);
        // Either side of half a turn, taking the pre-rotation path, then diagonals in all four quadrants.
        queue_sample(16'sh8000, 16'sd1, 16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, -16'sd1, 16'sd0, 1'b0);
        queue_sample(16'sd1, 16'sd1, 16'sd0, 1'b0);
        queue_sample(-16'sd1, -16'sd1, 16'sh7FFF, 1'b0);
        queue_sample(16'sd1, -16'sd1, 16'sh8000, 1'b0);
        queue_sample(-16'sd1, 16'sd1, -16'sd1, 1'b0);
        queue_sample(16'sh5555, 16'shAAAA, 16'sh5555, 1'b0);
        queue_sample(16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            rx = pick_axis();
            ry = pick_axis();
            if ($urandom_range(0, 7) == 0)
                ry = '0;
            else if ($urandom_range(0, 15) == 0)
                rx = '0;
            queue_sample(rx, ry, 16'($urandom()), n == 0 || n == DRAIN_AT);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (words_in != words_total)
            @(posedge clk);
        while (results_out != words_total)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        if (faults == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
